@@ rtl/ufe_pkg.sv @@
// Shared types and constants for the union-find engine.
package ufe_pkg;

  // Field widths at the stream ports
  localparam int NODE_W    = 10;
  localparam int SIZE_W    = 11;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 24;

  // Reported set size saturates here
  localparam logic [SIZE_W-1:0] SIZE_SAT = 11'd2047;

  // Table access strobes
  typedef struct packed {
    logic p_rd;
    logic p_wr;
    logic s_rd;
    logic s_wr;
  } ufe_mem_ctl_t;

endpackage

@@ rtl/ufe_tables.sv @@
// Parent and size tables of the union-find engine, one port each.
module ufe_tables
  import ufe_pkg::*;
#(
  parameter int NODES = 1024
) (
  input  logic                       clk,
  input  ufe_mem_ctl_t               ctl,
  input  logic [$clog2(NODES)-1:0]   p_addr,
  input  logic [$clog2(NODES)-1:0]   p_wdata,
  output logic [$clog2(NODES)-1:0]   p_rdata,
  input  logic [$clog2(NODES)-1:0]   s_addr,
  input  logic [$clog2(NODES+1)-1:0] s_wdata,
  output logic [$clog2(NODES+1)-1:0] s_rdata
);

  localparam int NW = $clog2(NODES);
  localparam int SW = $clog2(NODES + 1);

  logic [NW-1:0] pmem [NODES];
  logic [SW-1:0] smem [NODES];

  // Parent table: read-first, so a rewrite returns the old link
  always_ff @(posedge clk) begin
    if (ctl.p_wr) begin
      pmem[p_addr] <= p_wdata;
    end
    if (ctl.p_rd) begin
      p_rdata <= pmem[p_addr];
    end
  end

  // Size table, meaningful at roots only
  always_ff @(posedge clk) begin
    if (ctl.s_wr) begin
      smem[s_addr] <= s_wdata;
    end
    if (ctl.s_rd) begin
      s_rdata <= smem[s_addr];
    end
  end

endmodule

@@ rtl/union_find_engine.sv @@
// Top level of the union-find engine: sequencer, stream ports and result register.
// Disjoint-set engine with union by size and full path compression over NODES
// nodes. Each input word names two nodes (indices at or above NODES are taken as
// NODES-1) and asks for their union; one result word follows with the merge flag,
// the final root and the set size (saturating at 2047). After reset the tables are
// swept once, one entry per cycle, and no word is accepted in that time. One word
// is worked at a time through single-port parent and size tables with registered
// reads: each parent-link step passes through WALK and WCHK and each compression
// rewrite through CMP and CNX, so the work per word grows with the depths of its
// two nodes below their roots, which union by size keeps to at most log2(NODES).
// The next word is taken while a result still waits on the output.
module union_find_engine
  import ufe_pkg::*;
#(
  parameter int NODES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // node_a[9:0], node_b[19:10], zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // joined[0], root[10:1], set_size[21:11], pad
);

  localparam int NW  = $clog2(NODES);
  localparam int SW  = $clog2(NODES + 1);
  localparam int CW  = ((NW > NODE_W) ? NW : NODE_W) + 1;
  localparam int XW  = ((SW > SIZE_W) ? SW : SIZE_W) + 1;

  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);

  // Sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_WCHK  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_CNX   = 4'd5;
  localparam logic [3:0] S_SZA   = 4'd6;
  localparam logic [3:0] S_SZB   = 4'd7;
  localparam logic [3:0] S_SZC   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]    state, state_next;
  logic [NW-1:0] clr;
  logic [NW-1:0] cur;
  logic [NW-1:0] start;
  logic [NW-1:0] nb;
  logic [NW-1:0] ra;
  logic [NW-1:0] rb;
  logic [SW-1:0] sa;
  logic          side;

  logic          res_joined;
  logic [NW-1:0] res_root;
  logic [SW-1:0] res_size;

  ufe_mem_ctl_t  ctl;
  logic [NW-1:0] p_addr, p_wdata, p_rdata;
  logic [NW-1:0] s_addr;
  logic [SW-1:0] s_wdata, s_rdata;

  logic [NW-1:0] in_a, in_b;
  logic [NW-1:0] walk_root;
  logic          swap;
  logic [NW-1:0] big, little;
  logic [SW-1:0] sum;
  logic          out_free;
  logic [SIZE_W-1:0] size_out;

  // Clamp the incoming node indices into range
  function automatic logic [NW-1:0] clamp_node(input logic [NODE_W-1:0] v);
    logic [CW-1:0] ext;
    ext = CW'(v);
    if (ext >= CW'(NODES)) begin
      return LAST_NODE;
    end
    return NW'(ext);
  endfunction

  assign in_a = clamp_node(s_tdata[NODE_W-1:0]);
  assign in_b = clamp_node(s_tdata[2*NODE_W-1:NODE_W]);

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign walk_root = side ? rb : ra;

  // Merge decision: the smaller set goes under the larger, ties keep node_a's root
  assign swap   = (sa < s_rdata);
  assign big    = swap ? rb : ra;
  assign little = swap ? ra : rb;
  assign sum    = sa + s_rdata;

  // Table strobes and addresses
  always_comb begin
    ctl     = '0;
    p_addr  = cur;
    p_wdata = walk_root;
    s_addr  = ra;
    s_wdata = sum;
    unique case (state)
      S_CLEAR: begin
        ctl.p_wr = 1'b1;
        ctl.s_wr = 1'b1;
        p_addr   = clr;
        p_wdata  = clr;
        s_addr   = clr;
        s_wdata  = SW'(1);
      end
      S_WALK: begin
        ctl.p_rd = 1'b1;
      end
      S_CMP: begin
        p_addr = start;
        if (start != walk_root) begin
          ctl.p_rd = 1'b1;
          ctl.p_wr = 1'b1;
        end
      end
      S_SZA: begin
        ctl.s_rd = 1'b1;
      end
      S_SZB: begin
        s_addr = rb;
        if (ra != rb) begin
          ctl.s_rd = 1'b1;
        end
      end
      S_SZC: begin
        ctl.p_wr = 1'b1;
        ctl.s_wr = 1'b1;
        p_addr   = little;
        p_wdata  = big;
        s_addr   = big;
      end
      S_IDLE, S_WCHK, S_CNX, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr == LAST_NODE) state_next = S_IDLE;
      S_IDLE:  if (s_tvalid) state_next = S_WALK;
      S_WALK:  state_next = S_WCHK;
      S_WCHK:  state_next = (p_rdata == cur) ? S_CMP : S_WALK;
      S_CMP: begin
        if (start != walk_root) begin
          state_next = S_CNX;
        end else begin
          state_next = side ? S_SZA : S_WALK;
        end
      end
      S_CNX:   state_next = S_CMP;
      S_SZA:   state_next = S_SZB;
      S_SZB:   state_next = (ra == rb) ? S_DONE : S_SZC;
      S_SZC:   state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr <= clr + NW'(1);
      end
    end
  end

  // Walk, compression and merge datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cur   <= in_a;
        start <= in_a;
        nb    <= in_b;
        side  <= 1'b0;
      end
      S_WCHK: begin
        if (p_rdata == cur) begin
          if (side) rb <= cur;
          else      ra <= cur;
        end else begin
          cur <= p_rdata;
        end
      end
      S_CMP: begin
        // first walk done: start the second one from node_b
        if (start == walk_root && !side) begin
          side  <= 1'b1;
          cur   <= nb;
          start <= nb;
        end
      end
      S_CNX: begin
        start <= p_rdata;
      end
      S_SZB: begin
        sa         <= s_rdata;
        res_joined <= 1'b0;
        res_root   <= ra;
        res_size   <= s_rdata;
      end
      S_SZC: begin
        res_joined <= 1'b1;
        res_root   <= big;
        res_size   <= sum;
      end
      S_CLEAR, S_WALK, S_SZA, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Saturate the reported size
  assign size_out = (XW'(res_size) > XW'(SIZE_SAT)) ? SIZE_SAT : SIZE_W'(res_size);

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= M_TDATA_W'({size_out, NODE_W'(res_root), res_joined});
    end
  end

  ufe_tables #(
    .NODES (NODES)
  ) u_tables (
    .clk     (clk),
    .ctl     (ctl),
    .p_addr  (p_addr),
    .p_wdata (p_wdata),
    .p_rdata (p_rdata),
    .s_addr  (s_addr),
    .s_wdata (s_wdata),
    .s_rdata (s_rdata)
  );

endmodule

@@ rtl/ufe_checker.sv @@
// Port-level checks for the union-find engine, bound to the top level.
module ufe_checker
  import ufe_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // A held result word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // One word in flight: the input is closed in the cycle after a word is accepted
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input reopened straight after acceptance");

  // A merge always yields a set of two or more
  a_merge_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[21:11] >= 11'd2)
    else $error("merge reported with set size below two");

  // Every reported set holds at least one node
  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[21:11] != 11'd0)
    else $error("empty set reported");

endmodule

bind union_find_engine ufe_checker u_ufe_checker (.*);
